// File: rtl/timestamp_trigger_table_assert.svh
// Assertion macros used by the trigger table back end
`ifndef TIMESTAMP_TRIGGER_TABLE_ASSERT_SVH
`define TIMESTAMP_TRIGGER_TABLE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define TTT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define TTT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg
// Types and constants shared by the timestamp trigger table.
// ----------------------------------------------------------------------------
package ttt_pkg;
  localparam int Entries = 16;
  localparam int TagBits = 32;
  localparam int IdxW    = $clog2(Entries);
  localparam int CntW    = $clog2(Entries + 1);
  localparam int QDepth  = 2;

  typedef enum logic [2:0] {
    CMD_FRAME  = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_STREAM = 3'd4
  } cmd_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam logic KIND_FIRE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] time_value;
    logic [31:0] tag_in;
    logic        one_shot;
    logic [31:0] target_id;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] trig_id;
    logic [63:0] trig_time;
    logic [31:0] tag_out;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // Classified operation handed from the front part to the back part
  typedef enum logic [2:0] {
    OP_FRAME, OP_ADD, OP_REMOVE, OP_CLEAR, OP_STREAM, OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] time_value;
    logic [TagBits-1:0] tag;
    logic        one_shot;
    logic [31:0] target_id;
  } op_item_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SCAN, BK_RSCAN, BK_SHIFT, BK_DONE
  } bk_state_e;
endpackage

// File: rtl/ttt_front.sv
// ----------------------------------------------------------------------------
// ttt_front
// Accepts input transactions, classifies the command and queues the operation.
// ----------------------------------------------------------------------------
module ttt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  ttt_pkg::in_item_t data,
  output logic              op_valid,
  input  logic              op_take,
  output ttt_pkg::op_item_t op
);
  import ttt_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  op_item_t        q [QDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   fill;
  op_item_t        cls;
  logic            push, pop;

  // Classify the command
  always_comb begin
    cls.time_value = data.time_value;
    cls.tag        = data.tag_in[TagBits-1:0];
    cls.one_shot   = data.one_shot;
    cls.target_id  = data.target_id;
    unique case (data.cmd)
      CMD_FRAME:  cls.op = OP_FRAME;
      CMD_ADD:    cls.op = OP_ADD;
      CMD_REMOVE: cls.op = OP_REMOVE;
      CMD_CLEAR:  cls.op = OP_CLEAR;
      CMD_STREAM: cls.op = OP_STREAM;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign stall    = (fill == (PtrW+1)'(QDepth));
  assign push     = valid && !stall;
  assign op_valid = (fill != '0);
  assign pop      = op_valid && op_take;
  assign op       = q[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

// File: rtl/ttt_back.sv
// ----------------------------------------------------------------------------
// ttt_back
// Executes queued operations on the trigger table and emits result transactions.
// ----------------------------------------------------------------------------
module ttt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_take,
  input  ttt_pkg::op_item_t  op,
  output logic               valid,
  input  logic               stall,
  output ttt_pkg::out_item_t data
);
  import ttt_pkg::*;
  `include "timestamp_trigger_table_assert.svh"

  logic [63:0]        e_time   [Entries];
  logic [TagBits-1:0] e_tag    [Entries];
  logic [31:0]        e_ident  [Entries];
  logic               e_single [Entries];

  logic [CntW-1:0] count, count_next;
  logic [31:0]     next_ident;
  logic [63:0]     prev_time;
  logic            prev_valid;

  bk_state_e       state, state_next;
  op_item_t        cur;
  logic [CntW-1:0] rd, rd_next;   // read index during a scan
  logic [CntW-1:0] wr, wr_next;   // write index during compaction
  logic [1:0]      st_code, st_next;
  logic [31:0]     rid, rid_next;

  logic            out_full;
  logic            emit_fire, emit_done, out_free;
  logic [IdxW-1:0] ri, wi;
  logic            fire, keep, id_hit, copy_en;
  logic            add_en, load;

  assign out_free = !out_full || !stall;
  assign ri       = rd[IdxW-1:0];
  assign wi       = wr[IdxW-1:0];
  assign fire     = (cur.time_value >= e_time[ri]) &&
                    (!prev_valid || e_time[ri] > prev_time);
  assign keep     = !(fire && e_single[ri]);
  assign id_hit   = (e_ident[ri] == cur.target_id);

  // Next state and control
  always_comb begin
    state_next = state;
    count_next = count;
    rd_next    = rd;
    wr_next    = wr;
    st_next    = st_code;
    rid_next   = rid;
    op_take    = 1'b0;
    emit_fire  = 1'b0;
    emit_done  = 1'b0;
    copy_en    = 1'b0;
    add_en     = 1'b0;
    load       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (op_valid) begin
          op_take    = 1'b1;
          load       = 1'b1;
          rd_next    = '0;
          wr_next    = '0;
          st_next    = ST_OK;
          rid_next   = '0;
          unique case (op.op)
            OP_FRAME:  state_next = BK_SCAN;
            OP_REMOVE: state_next = BK_RSCAN;
            default:   state_next = BK_DONE;
          endcase
        end
      end
      // Walk entries, fire matches, compact survivors
      BK_SCAN: begin
        if (rd == count) begin
          count_next = wr;
          state_next = BK_DONE;
        end else if (!fire || out_free) begin
          emit_fire = fire;
          copy_en   = keep && (wr != rd);
          if (keep) wr_next = wr + 1'b1;
          rd_next = rd + 1'b1;
        end
      end
      // Search oldest matching id
      BK_RSCAN: begin
        if (rd == count) begin
          st_next    = ST_NOTFOUND;
          state_next = BK_DONE;
        end else if (id_hit) begin
          wr_next    = rd;
          rd_next    = rd + 1'b1;
          state_next = BK_SHIFT;
        end else begin
          rd_next = rd + 1'b1;
        end
      end
      // Shift the tail down by one
      BK_SHIFT: begin
        if (rd == count) begin
          count_next = count - 1'b1;
          state_next = BK_DONE;
        end else begin
          copy_en = 1'b1;
          wr_next = wr + 1'b1;
          rd_next = rd + 1'b1;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          emit_done  = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
    // Add and clear act on entry to the completion step
    if (state == BK_IDLE && op_valid) begin
      unique case (op.op)
        OP_ADD: begin
          if (count == CntW'(Entries)) begin
            st_next = ST_FULL;
          end else begin
            add_en     = 1'b1;
            rid_next   = next_ident;
            count_next = count + 1'b1;
          end
        end
        OP_CLEAR: count_next = '0;
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      count      <= '0;
      next_ident <= '0;
      prev_valid <= 1'b0;
      out_full   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (add_en) next_ident <= next_ident + 1'b1;
      if (load && op.op == OP_STREAM) prev_valid <= 1'b0;
      if (state == BK_SCAN && rd == count) prev_valid <= 1'b1;
      if (emit_fire || emit_done) out_full <= 1'b1;
      else if (!stall) out_full <= 1'b0;
    end
  end

  // Hold the operation and scan pointers
  always_ff @(posedge clk) begin
    rd      <= rd_next;
    wr      <= wr_next;
    st_code <= st_next;
    rid     <= rid_next;
    if (load) cur <= op;
    if (state == BK_SCAN && rd == count) prev_time <= cur.time_value;
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (add_en) begin
      e_time[count[IdxW-1:0]]   <= op.time_value;
      e_tag[count[IdxW-1:0]]    <= op.tag;
      e_ident[count[IdxW-1:0]]  <= next_ident;
      e_single[count[IdxW-1:0]] <= op.one_shot;
    end else if (copy_en) begin
      e_time[wi]   <= e_time[ri];
      e_tag[wi]    <= e_tag[ri];
      e_ident[wi]  <= e_ident[ri];
      e_single[wi] <= e_single[ri];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      data.kind      <= KIND_FIRE;
      data.trig_id   <= e_ident[ri];
      data.trig_time <= e_time[ri];
      data.tag_out   <= 32'(e_tag[ri]);
      data.status    <= ST_OK;
      data.last      <= 1'b0;
    end else if (emit_done) begin
      data.kind      <= KIND_DONE;
      data.trig_id   <= rid;
      data.trig_time <= '0;
      data.tag_out   <= '0;
      data.status    <= st_code;
      data.last      <= 1'b1;
    end
  end
  assign valid = out_full;

  `TTT_ASSERT_IMP(a_count_range, 1'b1, count <= CntW'(Entries), "count above capacity")
  `TTT_ASSERT_IMP(a_wr_behind, state == BK_SCAN, wr <= rd, "compaction overtook scan")
  `TTT_ASSERT_IMP(a_take_idle, op_take, state == BK_IDLE, "op taken while busy")
  `TTT_ASSERT_NXT(a_done_idle, state == BK_DONE && out_free, state == BK_IDLE,
                  "completion did not return to idle")
endmodule

// File: rtl/timestamp_trigger_table.sv
// Add, clear, new stream: acted on when taken in idle, then reported from the done state.
// Frame: one entry per cycle through the scan unit, except while a fired entry waits for the output.
// Remove: search for the id, then shift of the tail.
// Throughput: one item in flight in the back end; two more queue in front.
// Reset: rst synchronous, empties the table, id counter and queue at once.
// ----------------------------------------------------------------------------
// timestamp_trigger_table
// Table of timed alarms fired by frame timestamps, in insertion order.
// ----------------------------------------------------------------------------
module timestamp_trigger_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ttt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ttt_pkg::out_item_t out_data
);
  import ttt_pkg::*;

  logic     op_valid, op_take;
  op_item_t op;

  ttt_front u_front (
    .clk, .rst,
    .valid(in_valid), .stall(in_stall), .data(in_data),
    .op_valid, .op_take, .op
  );

  ttt_back u_back (
    .clk, .rst,
    .op_valid, .op_take, .op,
    .valid(out_valid), .stall(out_stall), .data(out_data)
  );
endmodule

// File: verif/tb_timestamp_trigger_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_trigger_table
// Drives frame, add, remove, clear, new-stream and unknown-command
// transactions into the trigger table and checks every fired and completion
// result in order against a behavioral model of the table kept in this bench.
// ----------------------------------------------------------------------------
module tb_timestamp_trigger_table;
  import ttt_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int CMD_BAD = 5;  // first unknown command code

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  timestamp_trigger_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Model state of the alarm table
  logic [63:0] tbl_time[$];
  logic [31:0] tbl_tag[$];
  logic [31:0] tbl_id[$];
  logic        tbl_once[$];
  logic [31:0] id_counter = '0;
  logic [63:0] last_stamp = '0;
  logic        last_stamp_ok = 1'b0;

  out_item_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  function automatic out_item_t done_result(logic [31:0] id, logic [1:0] st);
    out_item_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.trig_id = id;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Update the table for one transaction and queue the results it causes
  task automatic apply_to_table(input in_item_t it);
    out_item_t r;
    int k;
    logic [1:0] st;
    logic [31:0] rid;
    st = ST_OK;
    rid = '0;
    case (it.cmd)
      CMD_FRAME: begin
        k = 0;
        while (k < tbl_time.size()) begin
          if (it.time_value >= tbl_time[k] &&
              (!last_stamp_ok || tbl_time[k] > last_stamp)) begin
            r = '0;
            r.kind = KIND_FIRE;
            r.trig_id = tbl_id[k];
            r.trig_time = tbl_time[k];
            r.tag_out = tbl_tag[k];
            pending_results.push_back(r);
            if (tbl_once[k]) begin
              tbl_time.delete(k); tbl_tag.delete(k);
              tbl_id.delete(k); tbl_once.delete(k);
              continue;
            end
          end
          k++;
        end
        last_stamp = it.time_value;
        last_stamp_ok = 1'b1;
      end
      CMD_ADD: begin
        if (tbl_time.size() >= Entries) begin
          st = ST_FULL;
        end else begin
          tbl_time.push_back(it.time_value);
          tbl_tag.push_back(it.tag_in);
          tbl_id.push_back(id_counter);
          tbl_once.push_back(it.one_shot);
          rid = id_counter;
          id_counter = id_counter + 1;
        end
      end
      CMD_REMOVE: begin
        st = ST_NOTFOUND;
        for (k = 0; k < tbl_id.size(); k++) begin
          if (tbl_id[k] == it.target_id) begin
            tbl_time.delete(k); tbl_tag.delete(k);
            tbl_id.delete(k); tbl_once.delete(k);
            st = ST_OK;
            break;
          end
        end
      end
      CMD_CLEAR: begin
        tbl_time.delete(); tbl_tag.delete(); tbl_id.delete(); tbl_once.delete();
      end
      CMD_STREAM: last_stamp_ok = 1'b0;
      default: ;
    endcase
    pending_results.push_back(done_result(rid, st));
  endtask

  // Check accepted results; randomize the receiver stall; run the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t timeout", $realtime);
        $display("== FAIL ==");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result %p", $realtime, out_data);
          errors++;
        end else begin
          if (out_data !== pending_results[0]) begin
            $display("%0t mismatch expected %p actual %p", $realtime,
                     pending_results[0], out_data);
            errors++;
          end
          void'(pending_results.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Send one transaction and model it once accepted; valid stays high
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_to_table(it);
  endtask

  function automatic in_item_t make_item(logic [2:0] c, logic [63:0] t,
                                         logic [31:0] tag, logic once,
                                         logic [31:0] id);
    in_item_t it;
    it.cmd = c; it.time_value = t; it.tag_in = tag;
    it.one_shot = once; it.target_id = id;
    return it;
  endfunction

  // Mostly adds and frames with advancing time; sometimes random noise
  function automatic in_item_t random_item(ref logic [63:0] clock_now);
    int pick;
    logic [63:0] t;
    pick = $urandom_range(99);
    t = clock_now + $urandom_range(40);
    if ($urandom_range(19) == 0) t = {$urandom, $urandom};
    if (pick < 40) begin
      return make_item(CMD_ADD, t, $urandom, 1'($urandom_range(1)), $urandom);
    end else if (pick < 72) begin
      clock_now = clock_now + $urandom_range(25);
      if ($urandom_range(9) == 0) clock_now = clock_now - $urandom_range(50);
      return make_item(CMD_FRAME, clock_now, $urandom, 1'($urandom_range(1)),
                       $urandom);
    end else if (pick < 86) begin
      if (tbl_id.size() > 0 && $urandom_range(3) != 0)
        return make_item(CMD_REMOVE, t, $urandom, 1'($urandom_range(1)),
                         tbl_id[$urandom_range(tbl_id.size() - 1)]);
      return make_item(CMD_REMOVE, t, $urandom, 1'($urandom_range(1)),
                       id_counter + $urandom_range(3));
    end else if (pick < 91) begin
      return make_item(CMD_STREAM, t, $urandom, 1'($urandom_range(1)), $urandom);
    end else if (pick < 95) begin
      return make_item(CMD_CLEAR, t, $urandom, 1'($urandom_range(1)), $urandom);
    end
    return make_item(3'($urandom_range(7, CMD_BAD)), {$urandom, $urandom}, $urandom,
                     1'($urandom_range(1)), $urandom);
  endfunction

  typedef struct {
    in_item_t  stim;
    logic      typed;   // completion is known up front
    out_item_t done;
  } stim_row_t;

  stim_row_t script[$];

  task automatic add_row(in_item_t it, logic typed, out_item_t done);
    stim_row_t row;
    row.stim = it; row.typed = typed; row.done = done;
    script.push_back(row);
  endtask

  initial begin
    logic [63:0] clock_now;
    int n;
    int phase;
    // Directed table: empty frame, extremes, fill to full, remove, wrap-free
    add_row(make_item(CMD_FRAME, 64'd0, '0, 1'b0, '0), 1, done_result(0, ST_OK));
    add_row(make_item(CMD_REMOVE, '0, '0, 1'b0, 32'hFFFF_FFFF), 1,
            done_result(0, ST_NOTFOUND));
    add_row(make_item(CMD_ADD, 64'd0, 32'hFFFF_FFFF, 1'b1, '0), 1,
            done_result(0, ST_OK));
    add_row(make_item(CMD_ADD, '1, 32'h0, 1'b0, '1), 1, done_result(1, ST_OK));
    for (n = 2; n < Entries; n++)
      add_row(make_item(CMD_ADD, 64'd100 + n * 10, 32'hA5A5_0000 + n, n[0], '0), 1,
              done_result(n, ST_OK));
    add_row(make_item(CMD_ADD, 64'd5, 32'h1234, 1'b0, '0), 1,
            done_result(0, ST_FULL));
    add_row(make_item(CMD_FRAME, 64'd150, '0, 1'b0, '0), 0, '0);
    add_row(make_item(CMD_FRAME, 64'd120, '0, 1'b0, '0), 0, '0);  // time goes back
    add_row(make_item(CMD_REMOVE, '0, '0, 1'b0, 32'd1), 1, done_result(0, ST_OK));
    add_row(make_item(CMD_STREAM, '1, '1, 1'b1, '1), 1, done_result(0, ST_OK));
    add_row(make_item(CMD_FRAME, '1, '1, 1'b1, '1), 0, '0);
    add_row(make_item(3'(CMD_BAD), '1, '1, 1'b1, '1), 1, done_result(0, ST_OK));
    add_row(make_item(CMD_CLEAR, '0, '0, 1'b0, '0), 1, done_result(0, ST_OK));
    add_row(make_item(CMD_FRAME, '1, '0, 1'b0, '0), 1, done_result(0, ST_OK));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table; typed rows also check the model itself
    foreach (script[i]) begin
      send_item(script[i].stim);
      if (script[i].typed && pending_results[$] !== script[i].done) begin
        $display("%0t mismatch expected %p actual %p", $realtime,
                 script[i].done, pending_results[$]);
        errors++;
      end
    end

    // Random part in three idling phases
    clock_now = 64'd1000;
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 83 : 0;
      recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 37 : 0;
      for (n = 0; n < 70; n++) begin
        send_item(random_item(clock_now));
        // Hold off until the table has drained its results
        if (phase == 1 && n == 30) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/ttt_pkg.sv
rtl/ttt_front.sv
rtl/ttt_back.sv
rtl/timestamp_trigger_table.sv
verif/tb_timestamp_trigger_table.sv
